@@ rtl/csfw_pkg.sv @@
package csfw_pkg;

  // Field widths of the request and result items.
  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned THREAD_W = 8;
  localparam int unsigned KIND_W   = 3;

  // Configuration bus.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register index, taken from paddr[2].
  localparam logic REG_INITIAL_UNITS = 1'b0;
  localparam logic REG_UNIT_LIMIT    = 1'b1;

  // Request operation codes.
  localparam logic FUNC_WAIT = 1'b0;
  localparam logic FUNC_POST = 1'b1;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_GRANTED   = 3'd0,
    KIND_QUEUED    = 3'd1,
    KIND_REJECTED  = 3'd2,
    KIND_WOKEN     = 3'd3,
    KIND_POST_IDLE = 3'd4
  } kind_e;

  // One entry of the waiter queue.
  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [UNIT_W-1:0]   units;
  } waiter_t;

endpackage

@@ rtl/counting_semaphore_fifo_waiters.sv @@
// Counting semaphore with a first-in first-out queue of waiting threads.
// A wait, or a post on an empty queue, gives its single result in the cycle after the transfer.
// A post on a non-empty queue that wakes waiters holds the block while it accepts the post,
// reads and wakes queued waiters one at a time from the head, and then gives the final result.
// One request is in flight at a time; the next is taken once the last result is out.
// Reset is asynchronous and active low; the queue memory is not cleared.
module counting_semaphore_fifo_waiters #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [csfw_pkg::THREAD_W-1:0]       thread_id_i,
  input  logic [csfw_pkg::UNIT_W-1:0]         unit_count_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [csfw_pkg::KIND_W-1:0]         kind_o,
  output logic [csfw_pkg::THREAD_W-1:0]       woken_thread_o,
  output logic [csfw_pkg::UNIT_W-1:0]         units_left_o,
  output logic                                last_o,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [csfw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [csfw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [csfw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  localparam int unsigned UW = csfw_pkg::UNIT_W;
  localparam int unsigned TW = csfw_pkg::THREAD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FLUSH
  } state_e;

  state_e                 state_q, state_d;
  logic [UW-1:0]          avail_q, avail_d;
  logic [UW-1:0]          init_q, init_d;
  logic [UW-1:0]          limit_q, limit_d;
  logic [IdxW-1:0]        head_q, head_d;
  logic [IdxW-1:0]        tail_q, tail_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  csfw_pkg::kind_e        out_kind_q, out_kind_d;
  logic [TW-1:0]          out_thread_q, out_thread_d;
  logic [UW-1:0]          out_units_q, out_units_d;
  logic                   out_last_q, out_last_d;
  logic                   pend_q, pend_d;
  logic [TW-1:0]          pend_thread_q, pend_thread_d;
  logic [UW-1:0]          pend_units_q, pend_units_d;

  // Queue memory: one write port at the tail, one read port at the next head.
  csfw_pkg::waiter_t      waiter_mem [QUEUE_DEPTH];
  csfw_pkg::waiter_t      rd_entry_q;
  csfw_pkg::waiter_t      wr_entry;
  logic                   mem_we;

  logic                   out_free;
  logic                   in_xfer;
  logic                   cfg_write;
  logic [UW:0]            post_sum;
  logic [UW-1:0]          post_avail;
  logic [IdxW-1:0]        tail_inc;
  logic [IdxW-1:0]        head_inc;
  logic                   head_fits;

  // The output register can take a new result when empty or being drained.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_xfer   = in_valid_i && !in_stall_o;

  // Configuration port: writes complete in the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      csfw_pkg::REG_INITIAL_UNITS: prdata = {(csfw_pkg::APB_DATA_W - UW)'(0), init_q};
      default:                     prdata = {(csfw_pkg::APB_DATA_W - UW)'(0), limit_q};
    endcase
  end

  // Saturating add of a post and the wrapped queue pointers.
  assign post_sum   = {1'b0, avail_q} + {1'b0, unit_count_i};
  assign post_avail = (post_sum > {1'b0, limit_q}) ? limit_q : post_sum[UW-1:0];
  assign tail_inc   = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign head_inc   = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign head_fits  = (avail_q >= rd_entry_q.units);

  assign wr_entry.thread = thread_id_i;
  assign wr_entry.units  = unit_count_i;

  // Request handling, wake-up sequencing and configuration writes.
  always_comb begin
    state_d       = state_q;
    avail_d       = avail_q;
    init_d        = init_q;
    limit_d       = limit_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_kind_d    = out_kind_q;
    out_thread_d  = out_thread_q;
    out_units_d   = out_units_q;
    out_last_d    = out_last_q;
    pend_d        = pend_q;
    pend_thread_d = pend_thread_q;
    pend_units_d  = pend_units_q;
    mem_we        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_thread_d = thread_id_i;
          if (func_i == csfw_pkg::FUNC_WAIT) begin
            if (count_q == '0 && avail_q >= unit_count_i) begin
              avail_d     = avail_q - unit_count_i;
              out_kind_d  = csfw_pkg::KIND_GRANTED;
              out_units_d = avail_q - unit_count_i;
            end else if (count_q >= FullCnt) begin
              out_kind_d  = csfw_pkg::KIND_REJECTED;
              out_units_d = avail_q;
            end else begin
              mem_we      = 1'b1;
              tail_d      = tail_inc;
              count_d     = count_q + 1'b1;
              out_kind_d  = csfw_pkg::KIND_QUEUED;
              out_units_d = avail_q;
            end
          end else begin
            avail_d = post_avail;
            pend_d  = 1'b0;
            if (count_q == '0) begin
              out_kind_d   = csfw_pkg::KIND_POST_IDLE;
              out_thread_d = '0;
              out_units_d  = post_avail;
            end else begin
              // The head entry is read at this edge; decide in S_CHECK.
              out_valid_d = out_valid_q && out_stall_i;
              state_d     = S_CHECK;
            end
          end
        end
      end

      S_CHECK: begin
        if (out_free) begin
          if (head_fits) begin
            // Wake the head; the earlier woken thread goes out as not last.
            avail_d       = avail_q - rd_entry_q.units;
            head_d        = head_inc;
            count_d       = count_q - 1'b1;
            pend_d        = 1'b1;
            pend_thread_d = rd_entry_q.thread;
            pend_units_d  = avail_q - rd_entry_q.units;
            if (pend_q) begin
              out_valid_d  = 1'b1;
              out_kind_d   = csfw_pkg::KIND_WOKEN;
              out_thread_d = pend_thread_q;
              out_units_d  = pend_units_q;
              out_last_d   = 1'b0;
            end
            if (count_q == CntW'(1)) begin
              state_d = S_FLUSH;
            end
          end else begin
            // Head does not fit: close the post.
            out_valid_d = 1'b1;
            out_last_d  = 1'b1;
            if (pend_q) begin
              out_kind_d   = csfw_pkg::KIND_WOKEN;
              out_thread_d = pend_thread_q;
              out_units_d  = pend_units_q;
            end else begin
              out_kind_d   = csfw_pkg::KIND_POST_IDLE;
              out_thread_d = '0;
              out_units_d  = avail_q;
            end
            pend_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = csfw_pkg::KIND_WOKEN;
          out_thread_d = pend_thread_q;
          out_units_d  = pend_units_q;
          out_last_d   = 1'b1;
          pend_d       = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The user must make register writes only while the block is idle; the block does not enforce this.
    if (cfg_write) begin
      case (paddr[2])
        csfw_pkg::REG_INITIAL_UNITS: begin
          init_d  = pwdata[UW-1:0];
          avail_d = pwdata[UW-1:0];
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end
        default: begin
          limit_d = pwdata[UW-1:0];
        end
      endcase
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      avail_q       <= '0;
      init_q        <= '0;
      limit_q       <= '1;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= csfw_pkg::KIND_GRANTED;
      out_thread_q  <= '0;
      out_units_q   <= '0;
      out_last_q    <= 1'b0;
      pend_q        <= 1'b0;
      pend_thread_q <= '0;
      pend_units_q  <= '0;
    end else begin
      state_q       <= state_d;
      avail_q       <= avail_d;
      init_q        <= init_d;
      limit_q       <= limit_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      count_q       <= count_d;
      out_valid_q   <= out_valid_d;
      out_kind_q    <= out_kind_d;
      out_thread_q  <= out_thread_d;
      out_units_q   <= out_units_d;
      out_last_q    <= out_last_d;
      pend_q        <= pend_d;
      pend_thread_q <= pend_thread_d;
      pend_units_q  <= pend_units_d;
    end
  end

  // Queue memory. The read follows the next head so the data is ready
  // for the cycle after a pop.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      waiter_mem[tail_q] <= wr_entry;
    end
    rd_entry_q <= waiter_mem[head_d];
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign woken_thread_o = out_thread_q;
  assign units_left_o   = out_units_q;
  assign last_o         = out_last_q;

`ifndef NO_ASSERTIONS
  // The queue never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count above depth");

  // An empty or full queue has its head and tail at the same slot.
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FullCnt) |-> head_q == tail_q)
    else $error("head and tail disagree with count");

  // The wake-up check only runs on a non-empty queue.
  a_check_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> count_q != '0)
    else $error("wake-up check on an empty queue");

  // A post on an empty queue closes at once with an idle result.
  a_post_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && func_i == csfw_pkg::FUNC_POST && count_q == '0 && !cfg_write)
      |=> (out_valid_q && out_last_q && out_kind_q == csfw_pkg::KIND_POST_IDLE
           && state_q == S_IDLE))
    else $error("post on empty queue did not close");
`endif

endmodule

@@ test/tb_top.sv @@
module tb_top;

  localparam int unsigned QUEUE_DEPTH    = 16;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = QUEUE_DEPTH + 4;

  localparam int unsigned UNIT_W     = csfw_pkg::UNIT_W;
  localparam int unsigned THREAD_W   = csfw_pkg::THREAD_W;
  localparam int unsigned KIND_W     = csfw_pkg::KIND_W;
  localparam int unsigned APB_ADDR_W = csfw_pkg::APB_ADDR_W;
  localparam int unsigned APB_DATA_W = csfw_pkg::APB_DATA_W;

  // One expected result transfer.
  typedef struct packed {
    csfw_pkg::kind_e     kind;
    logic [THREAD_W-1:0] thread;
    logic [UNIT_W-1:0]   units_left;
    logic                last;
  } sem_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  func_i;
  logic [THREAD_W-1:0]   thread_id_i;
  logic [UNIT_W-1:0]     unit_count_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [KIND_W-1:0]     kind_o;
  logic [THREAD_W-1:0]   woken_thread_o;
  logic [UNIT_W-1:0]     units_left_o;
  logic                  last_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Semaphore state as the testbench sees it.
  logic [UNIT_W-1:0] sem_units;
  logic [UNIT_W-1:0] sem_limit;
  csfw_pkg::waiter_t waiters[$];
  sem_result_t       expected_results[$];

  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned hold_off_cycles;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  counting_semaphore_fifo_waiters #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .thread_id_i   (thread_id_i),
    .unit_count_i  (unit_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .woken_thread_o(woken_thread_o),
    .units_left_o  (units_left_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Appends one expected result.
  function automatic void push_result(csfw_pkg::kind_e kind, logic [THREAD_W-1:0] thread,
                                      logic last);
    sem_result_t res;
    res.kind       = kind;
    res.thread     = thread;
    res.units_left = sem_units;
    res.last       = last;
    expected_results.push_back(res);
  endfunction

  // Works out the results of one accepted request and updates the semaphore.
  function automatic void predict_request(logic func, logic [THREAD_W-1:0] thread,
                                          logic [UNIT_W-1:0] count);
    logic [UNIT_W:0]   sum;
    csfw_pkg::waiter_t entry;
    sem_result_t       tail_res;
    int unsigned       woken;
    woken = 0;
    if (func == csfw_pkg::FUNC_WAIT) begin
      if (waiters.size() == 0 && sem_units >= count) begin
        sem_units = sem_units - count;
        push_result(csfw_pkg::KIND_GRANTED, thread, 1'b1);
      end else if (waiters.size() >= QUEUE_DEPTH) begin
        push_result(csfw_pkg::KIND_REJECTED, thread, 1'b1);
      end else begin
        entry.thread = thread;
        entry.units  = count;
        waiters.push_back(entry);
        push_result(csfw_pkg::KIND_QUEUED, thread, 1'b1);
      end
    end else begin
      sum = {1'b0, sem_units} + {1'b0, count};
      sem_units = (sum > {1'b0, sem_limit}) ? sem_limit : sum[UNIT_W-1:0];
      // Wake waiters from the head while the head's request fits.
      while (waiters.size() > 0 && sem_units >= waiters[0].units) begin
        entry = waiters.pop_front();
        sem_units = sem_units - entry.units;
        push_result(csfw_pkg::KIND_WOKEN, entry.thread, 1'b0);
        woken++;
      end
      if (woken == 0) begin
        push_result(csfw_pkg::KIND_POST_IDLE, '0, 1'b1);
      end else begin
        tail_res = expected_results.pop_back();
        tail_res.last = 1'b1;
        expected_results.push_back(tail_res);
      end
    end
  endfunction

  // Offers one request after a random gap and predicts it on its transfer.
  task automatic send_request(input logic func, input logic [THREAD_W-1:0] thread,
                              input logic [UNIT_W-1:0] count);
    int unsigned gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < in_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    func_i       <= func;
    thread_id_i  <= thread;
    unit_count_i <= count;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_request(func, thread, count);
  endtask

  // Random request: small counts mostly, with full-range values and extremes.
  task automatic send_random_request();
    logic              func;
    logic [UNIT_W-1:0] count;
    int unsigned       pick;
    func = ($urandom_range(99) < 55) ? csfw_pkg::FUNC_WAIT : csfw_pkg::FUNC_POST;
    pick = $urandom_range(99);
    if (func == csfw_pkg::FUNC_WAIT) begin
      if (pick < 75) count = UNIT_W'($urandom_range(8));
      else if (pick < 88) count = UNIT_W'($urandom_range(120));
      else if (pick < 95) count = UNIT_W'($urandom_range(65535));
      else count = '1;
    end else begin
      if (pick < 70) count = UNIT_W'($urandom_range(12));
      else if (pick < 90) count = UNIT_W'($urandom_range(200));
      else if (pick < 97) count = UNIT_W'($urandom_range(65535));
      else count = '1;
    end
    send_request(func, THREAD_W'($urandom_range(255)), count);
  endtask

  // Drops valid and waits until every expected result has been seen.
  task automatic wait_until_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One configuration bus access: setup cycle, then access cycle.
  task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reads a register and compares it with the value it should hold.
  task automatic check_register(input logic index, input logic [UNIT_W-1:0] want);
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b0, {index, 2'b00}, '0, rdata);
    if (rdata[UNIT_W-1:0] !== want) begin
      report_mismatch(index == csfw_pkg::REG_INITIAL_UNITS ? "initial_units read" :
                      "unit_limit read", 32'(rdata[UNIT_W-1:0]), 32'(want));
    end
  endtask

  // Writes a register, reads it back and applies it to the prediction.
  task automatic write_register(input logic index, input logic [UNIT_W-1:0] value);
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b1, {index, 2'b00}, {{(APB_DATA_W-UNIT_W){1'b0}}, value}, rdata);
    if (index == csfw_pkg::REG_INITIAL_UNITS) begin
      sem_units = value;
      waiters.delete();
    end else begin
      sem_limit = value;
    end
    check_register(index, value);
  endtask

  // Register values after reset, and a zero-unit grant on an empty semaphore.
  task automatic test_reset_defaults();
    check_register(csfw_pkg::REG_INITIAL_UNITS, '0);
    check_register(csfw_pkg::REG_UNIT_LIMIT, '1);
    send_request(csfw_pkg::FUNC_WAIT, 8'd0, 16'd0);
  endtask

  // A zero-unit wait behind a blocked waiter stays queued until both wake.
  task automatic test_fifo_order();
    wait_until_idle();
    write_register(csfw_pkg::REG_INITIAL_UNITS, 16'd5);
    send_request(csfw_pkg::FUNC_WAIT, 8'd255, 16'd5);
    send_request(csfw_pkg::FUNC_WAIT, 8'd1, 16'd3);
    send_request(csfw_pkg::FUNC_WAIT, 8'd2, 16'd0);
    send_request(csfw_pkg::FUNC_POST, 8'd0, 16'd2);
    send_request(csfw_pkg::FUNC_POST, 8'd7, 16'd1);
  endtask

  // Fill the queue, get a rejection, then wake every waiter with one post.
  task automatic test_queue_full();
    int unsigned i;
    wait_until_idle();
    write_register(csfw_pkg::REG_INITIAL_UNITS, 16'd0);
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      send_request(csfw_pkg::FUNC_WAIT, THREAD_W'(i * 17), 16'd1);
    end
    send_request(csfw_pkg::FUNC_WAIT, 8'hAA, 16'hFFFF);
    send_request(csfw_pkg::FUNC_POST, 8'h55, 16'hFFFF);
  endtask

  // Initial units above a lowered limit load as is and clamp on the next post.
  task automatic test_limit_clamp();
    wait_until_idle();
    write_register(csfw_pkg::REG_INITIAL_UNITS, 16'd1000);
    write_register(csfw_pkg::REG_UNIT_LIMIT, 16'd50);
    send_request(csfw_pkg::FUNC_WAIT, 8'h55, 16'd0);
    send_request(csfw_pkg::FUNC_POST, 8'h00, 16'd0);
    send_request(csfw_pkg::FUNC_WAIT, 8'h0F, 16'd50);
  endtask

  // Random traffic from a fresh setting of both registers.
  task automatic test_random_traffic(input logic [UNIT_W-1:0] start_units,
                                     input logic [UNIT_W-1:0] units_cap,
                                     input int unsigned count);
    wait_until_idle();
    write_register(csfw_pkg::REG_UNIT_LIMIT, units_cap);
    write_register(csfw_pkg::REG_INITIAL_UNITS, start_units);
    repeat (count) send_random_request();
  endtask

  // The receiver holds off for a long stretch so the block backs up.
  task automatic test_output_holdoff(input int unsigned count);
    hold_off_cycles = 300;
    repeat (count) send_random_request();
  endtask

  // With a zero limit every post empties the counter.
  task automatic test_zero_limit(input int unsigned count);
    wait_until_idle();
    write_register(csfw_pkg::REG_UNIT_LIMIT, 16'd0);
    write_register(csfw_pkg::REG_INITIAL_UNITS, 16'd0);
    repeat (count) send_random_request();
  endtask

  // The receiver stalls at random, or for a requested stretch.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    sem_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, kind", 32'(kind_o), 0);
      end else begin
        want = expected_results.pop_front();
        if (kind_o !== want.kind) begin
          report_mismatch("kind", 32'(kind_o), 32'(want.kind));
        end
        if (woken_thread_o !== want.thread) begin
          report_mismatch("woken_thread", 32'(woken_thread_o), 32'(want.thread));
        end
        if (units_left_o !== want.units_left) begin
          report_mismatch("units_left", 32'(units_left_o), 32'(want.units_left));
        end
        if (last_o !== want.last) begin
          report_mismatch("last", 32'(last_o), 32'(want.last));
        end
      end
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR at %0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    func_i          = csfw_pkg::FUNC_WAIT;
    thread_id_i     = '0;
    unit_count_i    = '0;
    out_stall_i     = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    sem_units       = '0;
    sem_limit       = '1;
    hold_off_cycles = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    in_idle_pct     = 20;
    out_idle_pct    = 48;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_fifo_order();
    test_queue_full();
    test_limit_clamp();
    test_random_traffic(16'd20, 16'hFFFF, 150);

    in_idle_pct  = 48;
    out_idle_pct = 20;
    test_random_traffic(16'hFFFF, 16'd100, 150);
    test_output_holdoff(40);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_zero_limit(15);
    test_random_traffic(16'd0, 16'd60, 110);

    wait_until_idle();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/csfw_pkg.sv
rtl/counting_semaphore_fifo_waiters.sv
test/tb_top.sv
